/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the project.
// Each macro expects signals named clk and rst_n in the calling scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/skse_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted key set engine package
// Sizes, beat layouts, command codes and the cell control bundle.
// ----------------------------------------------------------------------------
package skse_pkg;

    localparam int CAPACITY = 32;
    localparam int KEY_BITS = 64;

    localparam int KEY_W = 64;
    localparam int CMD_W = 2;
    localparam int CNT_W = 6;
    localparam int IDX_W = $clog2(CAPACITY);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_REM  = 2'd2;
    localparam logic [1:0] CELL_ROT  = 2'd3;

    localparam int OUT_PRESENT = 0;
    localparam int OUT_KEY_LSB = 1;
    localparam int OUT_POS_LSB = OUT_KEY_LSB + KEY_W;
    localparam int OUT_TOT_LSB = OUT_POS_LSB + CNT_W;
    localparam int OUT_REFUSED = OUT_TOT_LSB + CNT_W;
    localparam int OUT_BITS    = OUT_REFUSED + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [1:0]       op;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] count;
    } skse_ctrl_t;

endpackage

/* hw/rtl/sorted_key_set_engine_top.sv */
// ----------------------------------------------------------------------------
// Sorted key set engine
// A chain of key cells kept in ascending order, with a small sequencer that
// runs insert, remove, find and dump commands against it.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat carries a key in s_axis_tdata and a command in s_axis_tuser.
// Insert, remove and find give one output beat each; dump gives one beat per
// stored key in ascending order, or a single empty beat when the set is empty.
// tlast marks the final beat caused by an input beat.
// A command is accepted in the idle state; in the execute state every cell
// compares its key with the probe in parallel and the chain shifts.
// A dump rotates the chain once per output beat. The next input beat is
// accepted once the block has returned to the idle state.
// The first output beat is registered from the execute or dump state.
// The output beat is held in a register; while the receiver stalls, the
// block finishes nothing further but still accepts one input beat.
// Reset empties the set at once; the cell contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_key_set_engine_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: key.
    input  logic [skse_pkg::KEY_W-1:0]         s_axis_tdata,
    // Fields from bit 0: command.
    input  logic [skse_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: was_present, key_out, position, element_total,
    // full_refused, zero fill.
    output logic [skse_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast
);
    import skse_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DUMP = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [KEY_BITS-1:0] probe_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [IDX_W-1:0]    ptr_reg;
    logic [IDX_W-1:0]    ptr_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_present_reg;
    logic                out_present_next;
    logic [KEY_W-1:0]    out_key_reg;
    logic [KEY_W-1:0]    out_key_next;
    logic [CNT_W-1:0]    out_pos_reg;
    logic [CNT_W-1:0]    out_pos_next;
    logic [CNT_W-1:0]    out_tot_reg;
    logic [CNT_W-1:0]    out_tot_next;
    logic                out_refused_reg;
    logic                out_refused_next;
    logic                out_last_reg;
    logic                out_last_next;

    skse_ctrl_t          ctrl;
    logic [KEY_BITS-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] bound;
    logic [CNT_W-1:0]    lb_idx;
    logic                hit;
    logic [KEY_BITS-1:0] hit_key;
    logic                slot_free;
    logic                accept;
    logic                dump_end;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [KEY_BITS-1:0] prev_k;
            logic [KEY_BITS-1:0] next_k;
            if (g == 0)
            begin : g_first
                assign prev_k = probe_reg;
            end
            else
            begin : g_mid_lo
                assign prev_k = cell_key[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign next_k = '0;
            end
            else
            begin : g_mid_hi
                assign next_k = cell_key[g+1];
            end
            skse_cell u_cell (
                .clk       (clk),
                .cell_pos  (IDX_W'(g)),
                .ctrl      (ctrl),
                .probe_key (probe_reg),
                .prev_key  (prev_k),
                .next_key  (next_k),
                .wrap_key  (cell_key[0]),
                .key       (cell_key[g]),
                .lt        (cell_lt[g]),
                .eq        (cell_eq[g])
            );
        end
    endgenerate

    always_comb
    begin
        bound[0] = !cell_lt[0];
        for (int i = 1; i < CAPACITY; i++)
        begin
            bound[i] = cell_lt[i-1] && !cell_lt[i];
        end
    end

    always_comb
    begin
        lb_idx  = '0;
        hit_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (bound[i])
            begin
                lb_idx = lb_idx | CNT_W'(i);
            end
            if (bound[i] && cell_eq[i])
            begin
                hit_key = hit_key | cell_key[i];
            end
        end
        if (cell_lt[CAPACITY-1])
        begin
            lb_idx = CNT_W'(CAPACITY);
        end
    end

    assign hit       = |(bound & cell_eq);
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign dump_end  = CNT_W'(ptr_reg) == count_reg - CNT_W'(1);

    assign s_axis_tready = state_reg == ST_IDLE;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        ctrl.op          = CELL_HOLD;
        ctrl.idx         = lb_idx;
        ctrl.count       = count_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_present_next = out_present_reg;
        out_key_next     = out_key_reg;
        out_pos_next     = out_pos_reg;
        out_tot_next     = out_tot_reg;
        out_refused_next = out_refused_reg;
        out_last_next    = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    out_present_next = hit;
                    out_key_next     = '0;
                    out_pos_next     = lb_idx;
                    out_tot_next     = count_reg;
                    out_refused_next = 1'b0;
                    out_last_next    = 1'b1;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (!hit && count_reg == CNT_W'(CAPACITY))
                            begin
                                out_refused_next = 1'b1;
                            end
                            else if (!hit)
                            begin
                                ctrl.op      = CELL_INS;
                                count_next   = count_reg + CNT_W'(1);
                                out_tot_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (hit)
                            begin
                                ctrl.op      = CELL_REM;
                                count_next   = count_reg - CNT_W'(1);
                                out_tot_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_FIND:
                        begin
                            out_key_next = KEY_W'(hit_key);
                        end
                        default:
                        begin
                            out_present_next = 1'b0;
                            out_pos_next     = '0;
                            if (count_reg != '0)
                            begin
                                out_valid_next = out_valid_reg && !m_axis_tready;
                                ptr_next       = '0;
                                state_next     = ST_DUMP;
                            end
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (slot_free)
                begin
                    ctrl.op          = CELL_ROT;
                    out_valid_next   = 1'b1;
                    out_present_next = 1'b1;
                    out_key_next     = KEY_W'(cell_key[0]);
                    out_pos_next     = CNT_W'(ptr_reg);
                    out_tot_next     = count_reg;
                    out_refused_next = 1'b0;
                    out_last_next    = dump_end;
                    ptr_next         = ptr_reg + IDX_W'(1);
                    if (dump_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_axis_tuser;
            probe_reg <= s_axis_tdata[KEY_BITS-1:0];
        end
        out_present_reg <= out_present_next;
        out_key_reg     <= out_key_next;
        out_pos_reg     <= out_pos_next;
        out_tot_reg     <= out_tot_next;
        out_refused_reg <= out_refused_next;
        out_last_reg    <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_refused_reg, out_tot_reg, out_pos_reg,
                                         out_key_reg, out_present_reg});

endmodule

/* hw/rtl/skse_cell.sv */
// ----------------------------------------------------------------------------
// Sorted key set cell
// Holds one key, compares it with the probe key and takes a neighbor's key
// when the chain shifts up, shifts down or rotates.
// ----------------------------------------------------------------------------
module skse_cell (
    input  logic                           clk,
    input  logic [skse_pkg::IDX_W-1:0]     cell_pos,
    input  skse_pkg::skse_ctrl_t           ctrl,
    input  logic [skse_pkg::KEY_BITS-1:0]  probe_key,
    input  logic [skse_pkg::KEY_BITS-1:0]  prev_key,
    input  logic [skse_pkg::KEY_BITS-1:0]  next_key,
    input  logic [skse_pkg::KEY_BITS-1:0]  wrap_key,
    output logic [skse_pkg::KEY_BITS-1:0]  key,
    output logic                           lt,
    output logic                           eq
);
    import skse_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [CNT_W-1:0]    pos_ext;
    logic                occ;

    assign pos_ext = CNT_W'(cell_pos);
    assign occ     = pos_ext < ctrl.count;
    assign lt      = occ && (key_reg < probe_key);
    assign eq      = occ && (key_reg == probe_key);
    assign key     = key_reg;

    always_comb
    begin
        key_next = key_reg;
        case (ctrl.op)
            CELL_INS:
            begin
                if (pos_ext > ctrl.idx)
                begin
                    key_next = prev_key;
                end
                else if (pos_ext == ctrl.idx)
                begin
                    key_next = probe_key;
                end
            end
            CELL_REM:
            begin
                if (pos_ext >= ctrl.idx)
                begin
                    key_next = next_key;
                end
            end
            CELL_ROT:
            begin
                if (pos_ext == ctrl.count - CNT_W'(1))
                begin
                    key_next = wrap_key;
                end
                else
                begin
                    key_next = next_key;
                end
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

/* hw/rtl/skse_checker.sv */
// ----------------------------------------------------------------------------
// Sorted key set engine checker
// Watches the top-level ports and flags handshake and result inconsistencies.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skse_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [skse_pkg::KEY_W-1:0]         s_axis_tdata,
    input  logic [skse_pkg::CMD_W-1:0]         s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [skse_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               m_axis_tlast
);
    import skse_pkg::*;

    logic             in_beat;
    logic             out_stall;
    logic             out_refused;
    logic [CNT_W-1:0] out_total;

    assign in_beat     = s_axis_tvalid && s_axis_tready && (s_axis_tuser <= CMD_DUMP)
                         && (s_axis_tdata == s_axis_tdata);
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_refused = m_axis_tdata[OUT_REFUSED];
    assign out_total   = m_axis_tdata[OUT_TOT_LSB +: CNT_W];

    `ASSERT_NEXT(a_out_hold, out_stall,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "Stalled output beat changed")
    `ASSERT_NEXT(a_busy_after_accept, in_beat, !s_axis_tready,
        "Input accepted again while a command is in progress")
    `ASSERT_IMPL(a_refused_full, m_axis_tvalid && out_refused,
        m_axis_tlast && !m_axis_tdata[OUT_PRESENT] && out_total == CNT_W'(CAPACITY),
        "Refused insert without a full store")
    `ASSERT_IMPL(a_dump_run, m_axis_tvalid && !m_axis_tlast,
        m_axis_tdata[OUT_PRESENT] && !out_refused,
        "Non-final beat that is not a valid dump entry")

endmodule

bind sorted_key_set_engine_top skse_checker u_skse_checker (.*);
